FILE: rtl/scc_pkg.sv
// Shared types and constants for the strong connectivity checker.
// No dependencies; used by every module of the block.
`default_nettype none

package scc_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 32;
  localparam int unsigned VTX_W            = 5;   // vertex index field width
  localparam int unsigned CNT_W            = 6;   // vertex count width
  localparam int unsigned MAXV_W           = 7;   // holds MAX_VERTICES up to 127

  typedef enum logic {
    FUNC_ADD   = 1'b0,
    FUNC_CHECK = 1'b1
  } scc_func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_FINISH
  } scc_state_e;

  // control shared by all cells of the ring
  typedef struct packed {
    logic load;   // set one adjacency bit
    logic shift;  // closure step and rotate
    logic clear;  // wipe the row
  } scc_cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/scc_cell.sv
// One ring cell: holds one adjacency row, does one closure step per cycle
// while shift is set. Depends on scc_pkg.
`default_nettype none

module scc_cell #(
  parameter int unsigned ROW_W = scc_pkg::MAX_VERTICES_DEF,
  parameter int unsigned KW    = 5,
  parameter int unsigned IDX   = 0
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire scc_pkg::scc_cell_ctrl_t  ctrl_i,
  input  wire [scc_pkg::VTX_W-1:0]      src_vertex_i,
  input  wire [ROW_W-1:0]               col_mask_i,
  input  wire [ROW_W-1:0]               pivot_i,
  input  wire [ROW_W-1:0]               next_upd_i,
  input  wire [KW-1:0]                  k_i,
  input  wire [scc_pkg::CNT_W-1:0]      count_i,
  input  wire [ROW_W-1:0]               full_i,
  output logic [ROW_W-1:0]              row_o,
  output logic [ROW_W-1:0]              upd_o,
  output logic                          ok_o
);

  localparam logic [ROW_W-1:0]          SELF   = ROW_W'(1) << IDX;
  localparam logic [scc_pkg::CNT_W-1:0] IDX_C  = scc_pkg::CNT_W'(IDX);

  logic [ROW_W-1:0] row_q, row_d;
  logic             hit;

  assign hit = ({1'b0, src_vertex_i} == IDX_C);

  // stored row as it stands, the pivot when this cell sits at the ring head
  assign row_o = row_q;

  // row | (row reaches pivot k ? pivot row : 0)
  assign upd_o = row_q[k_i] ? (row_q | pivot_i) : row_q;

  // vertex out of range never spoils the answer
  assign ok_o = (IDX_C >= count_i) || (&(row_q | SELF | ~full_i));

  always_comb begin
    row_d = row_q;
    if (ctrl_i.clear) begin
      row_d = '0;
    end else if (ctrl_i.shift) begin
      row_d = next_upd_i;
    end else if (ctrl_i.load && hit) begin
      row_d = row_q | col_mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/strong_connectivity_check_top.sv
// Edges are taken 1/cycle while idle and give no result. A check runs the closure over
//   N = min(MAX_VERTICES, 32) ring cells, then a finish state raises the result strobe;
//   on an empty graph it comes in the cycle after the check. busy_o is high in the
//   closure and finish states. Throughput is set by the closure ring: one pivot vertex
//   per cycle. The receiver cannot stall; done_o is a one-cycle strobe. Async active-low
//   reset clears all but the result payload. Depends on scc_pkg and scc_cell.
`default_nettype none

module strong_connectivity_check_top #(
  parameter int unsigned MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  wire                          func_i,
  input  wire [scc_pkg::VTX_W-1:0]     src_vertex_i,
  input  wire [scc_pkg::VTX_W-1:0]     dst_vertex_i,
  output logic                         done_o,
  output logic                         strongly_connected_o,
  output logic [scc_pkg::CNT_W-1:0]    vertex_count_o,
  output logic                         empty_graph_o
);

  // Vertex fields are 5 bits, so no more than 32 rows can ever be addressed.
  localparam int unsigned NUM_CELLS = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
  localparam int unsigned KW        = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam logic [scc_pkg::MAXV_W-1:0] MAXV   = scc_pkg::MAXV_W'(MAX_VERTICES);
  localparam logic [KW-1:0]              K_LAST = KW'(NUM_CELLS - 1);

  scc_pkg::scc_state_e     state_q, state_d;
  scc_pkg::scc_cell_ctrl_t cell_ctrl;

  logic [KW-1:0]                 k_q, k_d;
  logic [scc_pkg::VTX_W-1:0]     highest_q, highest_d;
  logic                          any_q, any_d;
  logic                          done_q, done_d;
  logic                          conn_q, conn_d;
  logic [scc_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                          empty_q, empty_d;

  logic                          accept;
  logic                          edge_ok;
  logic [scc_pkg::CNT_W-1:0]     count;
  logic [NUM_CELLS-1:0]          full;
  logic [NUM_CELLS-1:0]          col_mask;
  logic [NUM_CELLS-1:0]          row_w [NUM_CELLS];
  logic [NUM_CELLS-1:0]          upd_w [NUM_CELLS];
  logic [NUM_CELLS-1:0]          ok_w;

  assign accept  = start_i && (state_q == scc_pkg::ST_IDLE);
  assign edge_ok = ({2'b00, src_vertex_i} < MAXV) && ({2'b00, dst_vertex_i} < MAXV);
  assign count   = {1'b0, highest_q} + scc_pkg::CNT_W'(1);
  assign col_mask = NUM_CELLS'(1) << dst_vertex_i;

  // mask of the vertices in range 0..count-1
  always_comb begin
    for (int b = 0; b < NUM_CELLS; b++) begin
      full[b] = (scc_pkg::CNT_W'(b) < count);
    end
  end

  // Ring of cells: cell j takes the stepped row of cell j+1, so after s steps
  // cell 0 holds row s, which is the Warshall pivot for the next step. After
  // NUM_CELLS steps each row is back home holding its full reach set.
  // The pivot is the stored head row; stepping it with itself leaves it as is.
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    scc_cell #(
      .ROW_W (NUM_CELLS),
      .KW    (KW),
      .IDX   (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .src_vertex_i (src_vertex_i),
      .col_mask_i   (col_mask),
      .pivot_i      (row_w[0]),
      .next_upd_i   (upd_w[(g + 1) % NUM_CELLS]),
      .k_i          (k_q),
      .count_i      (count),
      .full_i       (full),
      .row_o        (row_w[g]),
      .upd_o        (upd_w[g]),
      .ok_o         (ok_w[g])
    );
  end

  // Controller
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    highest_d = highest_q;
    any_d     = any_q;
    done_d    = 1'b0;
    conn_d    = conn_q;
    cnt_d     = cnt_q;
    empty_d   = empty_q;
    cell_ctrl = '0;

    unique case (state_q)
      scc_pkg::ST_IDLE: begin
        if (accept) begin
          if (scc_pkg::scc_func_e'(func_i) == scc_pkg::FUNC_ADD) begin
            if (edge_ok) begin
              cell_ctrl.load = 1'b1;
              any_d          = 1'b1;
              if (src_vertex_i > highest_d) highest_d = src_vertex_i;
              if (dst_vertex_i > highest_d) highest_d = dst_vertex_i;
            end
          end else if (!any_q) begin
            // empty graph: fixed answer, nothing stored to clear
            done_d  = 1'b1;
            conn_d  = 1'b0;
            cnt_d   = '0;
            empty_d = 1'b1;
          end else begin
            k_d     = '0;
            state_d = scc_pkg::ST_CLOSE;
          end
        end
      end
      scc_pkg::ST_CLOSE: begin
        cell_ctrl.shift = 1'b1;
        k_d             = k_q + KW'(1);
        if (k_q == K_LAST) begin
          state_d = scc_pkg::ST_FINISH;
        end
      end
      scc_pkg::ST_FINISH: begin
        done_d          = 1'b1;
        conn_d          = &ok_w;
        cnt_d           = count;
        empty_d         = 1'b0;
        cell_ctrl.clear = 1'b1;
        highest_d       = '0;
        any_d           = 1'b0;
        state_d         = scc_pkg::ST_IDLE;
      end
      default: begin
        state_d = scc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= scc_pkg::ST_IDLE;
      k_q       <= '0;
      highest_q <= '0;
      any_q     <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      highest_q <= highest_d;
      any_q     <= any_d;
      done_q    <= done_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    conn_q  <= conn_d;
    cnt_q   <= cnt_d;
    empty_q <= empty_d;
  end

  assign busy_o               = (state_q != scc_pkg::ST_IDLE);
  assign done_o               = done_q;
  assign strongly_connected_o = conn_q;
  assign vertex_count_o       = cnt_q;
  assign empty_graph_o        = empty_q;

endmodule

`default_nettype wire

FILE: rtl/scc_checker.sv
// Port-level checker for strong_connectivity_check_top, attached by bind.
// Depends on scc_pkg.
`default_nettype none

module scc_checker (
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       start_i,
  input wire                       busy_o,
  input wire                       func_i,
  input wire                       done_o,
  input wire                       strongly_connected_o,
  input wire [scc_pkg::CNT_W-1:0]  vertex_count_o,
  input wire                       empty_graph_o
);

  // result strobe only once the ring is released
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // an edge transaction never yields a result
  a_edge_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && func_i == scc_pkg::FUNC_ADD) |=> !done_o)
    else $error("result after edge transaction");

  // a check either answers at once or starts the closure
  a_check_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && func_i == scc_pkg::FUNC_CHECK) |=> (done_o || busy_o))
    else $error("check transaction dropped");

  a_empty_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && empty_graph_o) |-> (vertex_count_o == '0 && !strongly_connected_o))
    else $error("empty graph result malformed");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !empty_graph_o) |-> (vertex_count_o != '0))
    else $error("zero vertex count on loaded graph");

endmodule

bind strong_connectivity_check_top scc_checker u_scc_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .start_i              (start_i),
  .busy_o               (busy_o),
  .func_i               (func_i),
  .done_o               (done_o),
  .strongly_connected_o (strongly_connected_o),
  .vertex_count_o       (vertex_count_o),
  .empty_graph_o        (empty_graph_o)
);

`default_nettype wire

FILE: tb/sv/strong_connectivity_check_checker.sv
// Scoreboard for the strong connectivity checker: mirrors the adjacency store,
// predicts the verdict of every check transaction and compares it on done_i.
// Depends on scc_pkg.
`timescale 1ns / 1ps

module strong_connectivity_check_checker #(
  parameter int unsigned MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start_i,
  input  wire                       busy_i,
  input  scc_pkg::scc_func_e        func_i,
  input  wire [scc_pkg::VTX_W-1:0]  src_vertex_i,
  input  wire [scc_pkg::VTX_W-1:0]  dst_vertex_i,
  input  wire                       done_i,
  input  wire                       strongly_connected_i,
  input  wire [scc_pkg::CNT_W-1:0]  vertex_count_i,
  input  wire                       empty_graph_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  typedef struct packed {
    logic                      connected;
    logic [scc_pkg::CNT_W-1:0] count;
    logic                      empty;
  } scc_verdict_t;

  logic [31:0]  adj_rows [32];
  logic [4:0]   top_vertex;
  logic         edge_seen;
  scc_verdict_t verdict_q [$];
  int           fails;

  assign fail_count_o = fails;

  function automatic void wipe_graph();
    for (int i = 0; i < 32; i++) adj_rows[i] = '0;
    top_vertex = '0;
    edge_seen  = 1'b0;
  endfunction

  // transitive closure from one pivot, true if it covers all vertices
  function automatic logic pivot_reaches_all(int unsigned pivot, int unsigned count);
    logic [63:0] full;
    logic [31:0] reach;
    logic [31:0] prev;
    full  = (64'd1 << count) - 64'd1;
    reach = 32'd1 << pivot;
    prev  = '0;
    while (reach != prev) begin
      prev = reach;
      for (int unsigned v = 0; v < count; v++)
        if (reach[v]) reach |= adj_rows[v];
    end
    return (reach & full[31:0]) == full[31:0];
  endfunction

  function automatic scc_verdict_t graph_verdict();
    scc_verdict_t res;
    int unsigned  count;
    res = '{connected: 1'b0, count: '0, empty: 1'b1};
    if (edge_seen) begin
      count         = top_vertex + 1;
      res.empty     = 1'b0;
      res.count     = scc_pkg::CNT_W'(count);
      res.connected = 1'b1;
      for (int unsigned v = 0; v < count; v++)
        if (!pivot_reaches_all(v, count)) res.connected = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scc_verdict_t exp_v;
    scc_verdict_t got_v;
    if (!rst_ni) begin
      wipe_graph();
      verdict_q.delete();
      fails     = 0;
      pending_o <= 0;
    end else begin
      if (start_i && !busy_i) begin
        if (func_i == scc_pkg::FUNC_ADD) begin
          if (src_vertex_i < MAX_VERTICES && dst_vertex_i < MAX_VERTICES) begin
            adj_rows[src_vertex_i][dst_vertex_i] = 1'b1;
            if (src_vertex_i > top_vertex) top_vertex = src_vertex_i;
            if (dst_vertex_i > top_vertex) top_vertex = dst_vertex_i;
            edge_seen = 1'b1;
          end
        end else begin
          verdict_q = {verdict_q, graph_verdict()};
          wipe_graph();
        end
      end
      if (done_i) begin
        got_v = '{connected: strongly_connected_i, count: vertex_count_i,
                  empty: empty_graph_i};
        if (verdict_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected verdict: connected=%0b count=%0d empty=%0b",
                     $realtime, got_v.connected, got_v.count, got_v.empty);
        end else begin
          exp_v = verdict_q.pop_front();
          if (got_v !== exp_v) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch: exp conn=%0b cnt=%0d empty=%0b, got %0b %0d %0b",
                       $realtime, exp_v.connected, exp_v.count, exp_v.empty,
                       got_v.connected, got_v.count, got_v.empty);
          end
        end
      end
      pending_o <= verdict_q.size();
    end
  end

endmodule

FILE: tb/sv/strong_connectivity_check_top_tb.sv
// Testbench top for strong_connectivity_check_top: builds graphs from edge
// transactions, issues check transactions and gives the verdict.
// Depends on scc_pkg, the block and strong_connectivity_check_checker.
`timescale 1ns / 1ps

module strong_connectivity_check_top_tb;

  localparam int unsigned NUM_ITEMS   = 1300;
  // worst case per transaction: a full idle gap plus a full check, taken ~7x
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 40;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  scc_pkg::scc_func_e          func_i;
  logic [scc_pkg::VTX_W-1:0]   src_vertex_i;
  logic [scc_pkg::VTX_W-1:0]   dst_vertex_i;
  logic                        done_o;
  logic                        strongly_connected_o;
  logic [scc_pkg::CNT_W-1:0]   vertex_count_o;
  logic                        empty_graph_o;

  int                  fail_count;
  int                  pending;
  int unsigned         cycles = 0;
  int unsigned         items_sent;
  logic                no_gaps;        // back-to-back stretch when set

  // edge list of the graph under construction, src in [9:5], dst in [4:0]
  logic [9:0]          edge_q [$];
  int unsigned         perm [32];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  strong_connectivity_check_top i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (start_i),
    .busy_o               (busy_o),
    .func_i               (func_i),
    .src_vertex_i         (src_vertex_i),
    .dst_vertex_i         (dst_vertex_i),
    .done_o               (done_o),
    .strongly_connected_o (strongly_connected_o),
    .vertex_count_o       (vertex_count_o),
    .empty_graph_o        (empty_graph_o)
  );

  strong_connectivity_check_checker i_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (start_i),
    .busy_i               (busy_o),
    .func_i               (func_i),
    .src_vertex_i         (src_vertex_i),
    .dst_vertex_i         (dst_vertex_i),
    .done_i               (done_o),
    .strongly_connected_i (strongly_connected_o),
    .vertex_count_i       (vertex_count_o),
    .empty_graph_i        (empty_graph_o),
    .fail_count_o         (fail_count),
    .pending_o            (pending)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[strong_connectivity_check_top] ERROR");
      $finish;
    end
  end

  // One transaction. Called right after a rising edge; start_i stays high
  // across back-to-back transactions so it is never dropped and raised in
  // the same step.
  task automatic send_txn(scc_pkg::scc_func_e fn,
                          logic [scc_pkg::VTX_W-1:0] src,
                          logic [scc_pkg::VTX_W-1:0] dst);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    func_i       <= fn;
    src_vertex_i <= src;
    dst_vertex_i <= dst;
    // busy_o only moves on rising edges, so the falling edge shows the value
    // that the next rising edge will see
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    items_sent++;
  endtask

  task automatic add_edge(int unsigned src, int unsigned dst);
    send_txn(scc_pkg::FUNC_ADD, scc_pkg::VTX_W'(src), scc_pkg::VTX_W'(dst));
  endtask

  // Fields of a check transaction are don't-care: keep them random.
  task automatic check_graph();
    send_txn(scc_pkg::FUNC_CHECK, scc_pkg::VTX_W'($urandom), scc_pkg::VTX_W'($urandom));
  endtask

  // Shuffle the collected edges so that load order is random, then send.
  task automatic flush_edges();
    int unsigned j;
    logic [9:0]  tmp;
    for (int i = edge_q.size() - 1; i > 0; i--) begin
      j         = $urandom_range(0, i);
      tmp       = edge_q[i];
      edge_q[i] = edge_q[j];
      edge_q[j] = tmp;
    end
    foreach (edge_q[i]) add_edge(edge_q[i][9:5], edge_q[i][4:0]);
    edge_q.delete();
  endtask

  function automatic void enqueue_edge(logic [9:0] e);
    edge_q = {edge_q, e};
  endfunction

  function automatic void shuffle_vertices(int unsigned n);
    int unsigned j;
    int unsigned tmp;
    for (int unsigned i = 0; i < n; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
  endfunction

  // Directed cycle over perm[lo..hi-1]; the edge at index 'skip' is left out
  // (skip < 0 keeps the cycle whole). A one-vertex cycle is a self loop.
  function automatic void push_cycle(int lo, int hi, int skip);
    for (int i = lo; i < hi; i++)
      if (i != skip)
        enqueue_edge({5'(perm[i]), 5'(perm[(i + 1 < hi) ? i + 1 : lo])});
  endfunction

  function automatic void push_extras(int unsigned n, int unsigned num);
    for (int unsigned i = 0; i < num; i++)
      enqueue_edge({5'($urandom_range(0, n - 1)), 5'($urandom_range(0, n - 1))});
  endfunction

  initial begin
    int unsigned mode;
    int unsigned n;
    int unsigned k;
    int unsigned dir;

    rst_ni       = 1'b0;
    start_i      = 1'b0;
    func_i       = scc_pkg::FUNC_ADD;
    src_vertex_i = '0;
    dst_vertex_i = '0;
    items_sent   = 0;
    no_gaps      = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---------------- directed part ----------------
    // check straight after reset: empty graph, check fields at all ones
    send_txn(scc_pkg::FUNC_CHECK, '1, '1);
    // single self loop on vertex 0: one vertex, trivially connected
    add_edge(0, 0);
    check_graph();
    // one-way edge: vertex 1 cannot get back to 0
    add_edge(0, 1);
    check_graph();
    // two-vertex cycle with a self loop thrown in: connected
    add_edge(0, 1);
    add_edge(1, 1);
    add_edge(1, 0);
    check_graph();
    // self loop on the top vertex: count 32, everything else isolated
    add_edge(31, 31);
    check_graph();
    // both extremes linked both ways, vertices 1..30 isolated
    add_edge(0, 31);
    add_edge(31, 0);
    check_graph();
    // store must be clear again after the previous check
    send_txn(scc_pkg::FUNC_CHECK, '0, '1);
    no_gaps = 1'b1;
    add_edge(31, 0);
    add_edge(0, 31);
    check_graph();
    check_graph();

    // ---------------- random part ----------------
    // Many well-formed graphs (cycles with random content) so that both verdicts
    // come up often; the rest is broken cycles, joined cycle pairs, noise and empties.
    while (items_sent < NUM_ITEMS) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      n       = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
      mode    = $urandom_range(0, 9);
      shuffle_vertices(n);
      case (mode)
        0, 1, 2, 3: begin
          // whole cycle plus chords: connected
          push_cycle(0, n, -1);
          push_extras(n, $urandom_range(0, n));
        end
        4, 5: begin
          // cycle with one edge missing, chords may or may not repair it
          push_cycle(0, n, $urandom_range(0, n - 1));
          push_extras(n, $urandom_range(0, 2));
        end
        6: begin
          // noise over the full vertex range
          push_extras(32, $urandom_range(1, 12));
        end
        7: begin
          // empty graph: check with nothing loaded
        end
        default: begin
          // a pair of graph cycles joined both ways, one way, or not at all
          if (n < 2) n = 2 + $urandom_range(0, 6);
          shuffle_vertices(n);
          k   = $urandom_range(1, n - 1);
          dir = $urandom_range(0, 2);
          push_cycle(0, k, -1);
          push_cycle(k, n, -1);
          if (dir != 2)
            enqueue_edge({5'(perm[$urandom_range(0, k - 1)]),
                          5'(perm[$urandom_range(k, n - 1)])});
          if (dir == 0)
            enqueue_edge({5'(perm[$urandom_range(k, n - 1)]),
                          5'(perm[$urandom_range(0, k - 1)])});
        end
      endcase
      flush_edges();
      check_graph();
    end

    // ---------------- drain ----------------
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("[strong_connectivity_check_top] OK");
    end else begin
      $display("[strong_connectivity_check_top] ERROR");
    end
    $finish;
  end

endmodule
